// File: design/hrd_pkg.sv
// Shared types and constants for the hextile rectangle decoder.
// No dependencies; imported by the front, back and top-level modules.
package hrd_pkg;

  localparam int unsigned TILE_SIZE = 16;

  // Subencoding flag bit positions
  localparam int unsigned F_RAW_BIT  = 0;
  localparam int unsigned F_BACK_BIT = 1;
  localparam int unsigned F_FORE_BIT = 2;
  localparam int unsigned F_RECT_BIT = 3;
  localparam int unsigned F_COLS_BIT = 4;

  localparam logic [2:0] PIX_BYTES_RESET = 3'd4;

  // operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Classified request passed from front to back
  typedef struct packed {
    logic        is_begin;
    logic        empty_rect;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  data;
  } hrd_item_t;

endpackage

// File: design/hextile_rectangle_decoder_unit.sv
// Hextile rectangle decoder top level: front queue plus back decoder.
// Depends on hrd_pkg, hrd_front and hrd_back.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o): operation_i = 0 starts a rectangle
//   of rect_width_i by rect_height_i; operation_i = 1 delivers one encoded
//   stream byte on data_byte_i. A request is taken on a clock edge with valid
//   high and stall low. Bytes outside a rectangle are dropped.
// - Output channel (out_valid_o / out_stall_i): one fill per request, at most,
//   in rectangle-relative coordinates; last_o flags the final fill.
// - Config channel (cfg_valid_i / cfg_ready_o): bytes per pixel colour. Always
//   ready; write only while the decoder is idle.
// Path: a fill's request passes through the front queue and then the decoder
//   step, whose result is held in the registered fill output.
// Throughput: one request per cycle while the queue is not full; every stream
//   byte is a single decoder step, so the back end retires one request per
//   cycle while the output register is free.
// Stall: when out_stall_i holds a fill, the decoder stops; the front queue of
//   QUEUE_DEPTH requests keeps accepting until it fills, then raises in_stall_o.
// Reset: async, active low; clears queue, decoder (idle) and output valid;
//   bytes per pixel returns to 4.
module hextile_rectangle_decoder_unit import hrd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_pixel_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] fill_x_o,
  output logic [15:0] fill_y_o,
  output logic [4:0]  fill_width_o,
  output logic [4:0]  fill_height_o,
  output logic [31:0] color_o,
  output logic        last_o
);

  logic      q_valid;
  logic      q_pop;
  hrd_item_t q_item;

  // register write is a single flop load, never blocked
  assign cfg_ready_o = 1'b1;

  hrd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .data_byte_i  (data_byte_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  hrd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_pixel_bytes_i(cfg_pixel_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fill_x_o         (fill_x_o),
    .fill_y_o         (fill_y_o),
    .fill_width_o     (fill_width_o),
    .fill_height_o    (fill_height_o),
    .color_o          (color_o),
    .last_o           (last_o)
  );

endmodule

// File: design/hrd_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on hrd_pkg.
module hrd_front import hrd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  input  logic [7:0]  data_byte_i,
  output logic        q_valid_o,
  output hrd_item_t   q_item_o,
  input  logic        q_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  hrd_item_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            full, push, pop;
  hrd_item_t       item;

  // classify
  always_comb begin
    item.is_begin   = (operation_i == OP_BEGIN);
    item.empty_rect = (rect_width_i == 16'd0) || (rect_height_i == 16'd0);
    item.width      = rect_width_i;
    item.height     = rect_height_i;
    item.data       = data_byte_i;
  end

  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// File: design/hrd_back.sv
// Back end: hextile tile walker and decoder, with the registered fill output.
// Depends on hrd_pkg; fed by hrd_front.
module hrd_back import hrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  hrd_item_t   q_item_i,
  output logic        q_pop_o,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_pixel_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] fill_x_o,
  output logic [15:0] fill_y_o,
  output logic [4:0]  fill_width_o,
  output logic [4:0]  fill_height_o,
  output logic [31:0] color_o,
  output logic        last_o
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SUBENC = 4'd1;
  localparam logic [3:0] PH_BG     = 4'd2;
  localparam logic [3:0] PH_FG     = 4'd3;
  localparam logic [3:0] PH_NSUB   = 4'd4;
  localparam logic [3:0] PH_RAW    = 4'd5;
  localparam logic [3:0] PH_SUBCOL = 4'd6;
  localparam logic [3:0] PH_SUBXY  = 4'd7;
  localparam logic [3:0] PH_SUBWH  = 4'd8;

  // header stage already read
  localparam logic [1:0] HL_NONE = 2'd0;
  localparam logic [1:0] HL_BACK = 2'd1;
  localparam logic [1:0] HL_FORE = 2'd2;

  localparam logic [16:0] TILE17 = 17'(TILE_SIZE);
  localparam logic [4:0]  TILE5  = 5'(TILE_SIZE);

  logic [2:0]  pix_bytes_q;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] rect_w_q, rect_w_d, rect_h_q, rect_h_d;
  logic [15:0] org_x_q, org_x_d, org_y_q, org_y_d;
  logic [4:0]  flags_q, flags_d;
  logic [31:0] bg_q, bg_d, fg_q, fg_d, acc_q, acc_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [7:0]  nsub_q, nsub_d;
  logic [3:0]  raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic [7:0]  first_q, first_d;

  logic        out_valid_q;
  logic [15:0] fx_q, fy_q;
  logic [4:0]  fw_q, fh_q;
  logic [31:0] fc_q;
  logic        fl_q;

  logic        can_go, pop;
  logic [15:0] rem_w, rem_h;
  logic [4:0]  tile_w, tile_h;
  logic [16:0] nx, ny;
  logic        last_tile;
  logic [2:0]  pb_eff;
  logic [31:0] acc_new;
  logic        col_done;
  logic [1:0]  bidx_new;
  logic [7:0]  b;

  logic        emit, do_end, hdr, raw_done;
  logic [1:0]  hdr_lvl;
  logic [15:0] e_x, e_y;
  logic [4:0]  e_w, e_h;
  logic [31:0] e_c;
  logic        e_last;

  assign can_go  = !out_valid_q || !out_stall_i;
  assign pop     = q_valid_i && can_go;
  assign q_pop_o = pop;
  assign b       = q_item_i.data;

  // tile geometry
  assign rem_w     = rect_w_q - org_x_q;
  assign rem_h     = rect_h_q - org_y_q;
  assign tile_w    = (rem_w > 16'(TILE_SIZE)) ? TILE5 : rem_w[4:0];
  assign tile_h    = (rem_h > 16'(TILE_SIZE)) ? TILE5 : rem_h[4:0];
  assign nx        = {1'b0, org_x_q} + TILE17;
  assign ny        = {1'b0, org_y_q} + TILE17;
  assign last_tile = (nx >= {1'b0, rect_w_q}) && (ny >= {1'b0, rect_h_q});

  // colour byte assembly; out-of-range byte counts clamp to 1..4
  always_comb begin
    if (pix_bytes_q == 3'd0) begin
      pb_eff = 3'd1;
    end else if (pix_bytes_q > 3'd4) begin
      pb_eff = 3'd4;
    end else begin
      pb_eff = pix_bytes_q;
    end
    case (bidx_q)
      2'd0:    acc_new = {24'd0, b};
      2'd1:    acc_new = acc_q | {16'd0, b, 8'd0};
      2'd2:    acc_new = acc_q | {8'd0, b, 16'd0};
      default: acc_new = acc_q | {b, 24'd0};
    endcase
    col_done = ({1'b0, bidx_q} >= (pb_eff - 3'd1));
    bidx_new = col_done ? 2'd0 : bidx_q + 2'd1;
  end

  always_comb begin
    phase_d  = phase_q;
    rect_w_d = rect_w_q;
    rect_h_d = rect_h_q;
    org_x_d  = org_x_q;
    org_y_d  = org_y_q;
    flags_d  = flags_q;
    bg_d     = bg_q;
    fg_d     = fg_q;
    acc_d    = acc_q;
    bidx_d   = bidx_q;
    nsub_d   = nsub_q;
    raw_x_d  = raw_x_q;
    raw_y_d  = raw_y_q;
    first_d  = first_q;
    emit     = 1'b0;
    do_end   = 1'b0;
    hdr      = 1'b0;
    hdr_lvl  = HL_NONE;
    raw_done = 1'b0;
    e_x      = org_x_q;
    e_y      = org_y_q;
    e_w      = tile_w;
    e_h      = tile_h;
    e_c      = bg_q;
    e_last   = last_tile;

    if (pop) begin
      if (q_item_i.is_begin) begin
        rect_w_d = q_item_i.width;
        rect_h_d = q_item_i.height;
        org_x_d  = '0;
        org_y_d  = '0;
        bg_d     = '0;
        fg_d     = '0;
        acc_d    = '0;
        bidx_d   = '0;
        nsub_d   = '0;
        raw_x_d  = '0;
        raw_y_d  = '0;
        flags_d  = '0;
        phase_d  = q_item_i.empty_rect ? PH_IDLE : PH_SUBENC;
      end else begin
        case (phase_q)
          PH_SUBENC: begin
            flags_d = b[4:0];
            bidx_d  = '0;
            if (b[F_RAW_BIT]) begin
              raw_x_d = '0;
              raw_y_d = '0;
              phase_d = PH_RAW;
            end else begin
              hdr     = 1'b1;
              hdr_lvl = HL_NONE;
            end
          end
          PH_BG: begin
            acc_d  = acc_new;
            bidx_d = bidx_new;
            if (col_done) begin
              bg_d    = acc_new;
              hdr     = 1'b1;
              hdr_lvl = HL_BACK;
            end
          end
          PH_FG: begin
            acc_d  = acc_new;
            bidx_d = bidx_new;
            if (col_done) begin
              fg_d    = acc_new;
              hdr     = 1'b1;
              hdr_lvl = HL_FORE;
            end
          end
          PH_NSUB: begin
            nsub_d = b;
            emit   = 1'b1;
            e_last = last_tile && (b == 8'd0);
            if (b == 8'd0) begin
              do_end = 1'b1;
            end else begin
              bidx_d  = '0;
              phase_d = flags_q[F_COLS_BIT] ? PH_SUBCOL : PH_SUBXY;
            end
          end
          PH_RAW: begin
            acc_d  = acc_new;
            bidx_d = bidx_new;
            if (col_done) begin
              raw_done = ({1'b0, raw_x_q} == tile_w - 5'd1) &&
                         ({1'b0, raw_y_q} == tile_h - 5'd1);
              emit   = 1'b1;
              e_x    = org_x_q + {12'd0, raw_x_q};
              e_y    = org_y_q + {12'd0, raw_y_q};
              e_w    = 5'd1;
              e_h    = 5'd1;
              e_c    = acc_new;
              e_last = raw_done && last_tile;
              if (raw_done) begin
                do_end = 1'b1;
              end else if ({1'b0, raw_x_q} == tile_w - 5'd1) begin
                raw_x_d = '0;
                raw_y_d = raw_y_q + 4'd1;
              end else begin
                raw_x_d = raw_x_q + 4'd1;
              end
            end
          end
          PH_SUBCOL: begin
            acc_d  = acc_new;
            bidx_d = bidx_new;
            if (col_done) begin
              phase_d = PH_SUBXY;
            end
          end
          PH_SUBXY: begin
            first_d = b;
            phase_d = PH_SUBWH;
          end
          PH_SUBWH: begin
            emit   = 1'b1;
            e_x    = org_x_q + {12'd0, first_q[7:4]};
            e_y    = org_y_q + {12'd0, first_q[3:0]};
            e_w    = {1'b0, b[7:4]} + 5'd1;
            e_h    = {1'b0, b[3:0]} + 5'd1;
            e_c    = flags_q[F_COLS_BIT] ? acc_q : fg_q;
            e_last = (nsub_q <= 8'd1) && last_tile;
            if (nsub_q <= 8'd1) begin
              nsub_d = '0;
              do_end = 1'b1;
            end else begin
              nsub_d  = nsub_q - 8'd1;
              bidx_d  = '0;
              phase_d = flags_q[F_COLS_BIT] ? PH_SUBCOL : PH_SUBXY;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        // next header stage, or the tile's background fill
        if (hdr) begin
          if ((hdr_lvl == HL_NONE) && flags_d[F_BACK_BIT]) begin
            phase_d = PH_BG;
            bidx_d  = '0;
          end else if ((hdr_lvl != HL_FORE) && flags_d[F_FORE_BIT]) begin
            phase_d = PH_FG;
            bidx_d  = '0;
          end else if (flags_d[F_RECT_BIT]) begin
            phase_d = PH_NSUB;
          end else begin
            emit   = 1'b1;
            e_c    = bg_d;
            e_last = last_tile;
            do_end = 1'b1;
          end
        end

        // advance to the next tile
        if (do_end) begin
          if (nx < {1'b0, rect_w_q}) begin
            org_x_d = nx[15:0];
            phase_d = PH_SUBENC;
          end else if (ny < {1'b0, rect_h_q}) begin
            org_x_d = '0;
            org_y_d = ny[15:0];
            phase_d = PH_SUBENC;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bytes_q <= PIX_BYTES_RESET;
      phase_q     <= PH_IDLE;
      rect_w_q    <= '0;
      rect_h_q    <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      flags_q     <= '0;
      bg_q        <= '0;
      fg_q        <= '0;
      acc_q       <= '0;
      bidx_q      <= '0;
      nsub_q      <= '0;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pix_bytes_q <= cfg_pixel_bytes_i;
      end
      phase_q  <= phase_d;
      rect_w_q <= rect_w_d;
      rect_h_q <= rect_h_d;
      org_x_q  <= org_x_d;
      org_y_q  <= org_y_d;
      flags_q  <= flags_d;
      bg_q     <= bg_d;
      fg_q     <= fg_d;
      acc_q    <= acc_d;
      bidx_q   <= bidx_d;
      nsub_q   <= nsub_d;
      raw_x_q  <= raw_x_d;
      raw_y_q  <= raw_y_d;
      first_q  <= first_d;
      if (can_go) begin
        out_valid_q <= pop && emit;
      end
    end
  end

  // fill payload
  always_ff @(posedge clk_i) begin
    if (can_go && pop && emit) begin
      fx_q <= e_x;
      fy_q <= e_y;
      fw_q <= e_w;
      fh_q <= e_h;
      fc_q <= e_c;
      fl_q <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fill_x_o      = fx_q;
  assign fill_y_o      = fy_q;
  assign fill_width_o  = fw_q;
  assign fill_height_o = fh_q;
  assign color_o       = fc_q;
  assign last_o        = fl_q;

endmodule

// File: design/hrd_checker.sv
// Port-level checks for the hextile rectangle decoder output channel.
// Depends on nothing; bound to hextile_rectangle_decoder_unit below.
module hrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] fill_x_o,
  input logic [15:0] fill_y_o,
  input logic [4:0]  fill_width_o,
  input logic [4:0]  fill_height_o,
  input logic [31:0] color_o,
  input logic        last_o
);

  // a held fill stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("fill dropped while stalled");

  // a held fill keeps its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fill_x_o) && $stable(fill_y_o) &&
      $stable(fill_width_o) && $stable(fill_height_o) && $stable(color_o) &&
      $stable(last_o))
    else $error("fill payload changed while stalled");

  // fill sizes are always within one tile
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_width_o != 5'd0 && fill_width_o <= 5'd16 &&
      fill_height_o != 5'd0 && fill_height_o <= 5'd16)
    else $error("fill size out of range");

  // no fill during reset; flops are still unknown before the first edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> out_valid_o !== 1'b1)
    else $error("fill valid during reset");

endmodule

bind hextile_rectangle_decoder_unit hrd_checker u_hrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .fill_x_o     (fill_x_o),
  .fill_y_o     (fill_y_o),
  .fill_width_o (fill_width_o),
  .fill_height_o(fill_height_o),
  .color_o      (color_o),
  .last_o       (last_o)
);
